FILE: rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants for the linear probe hash table
// Field widths, operation, slot and status codes, FSM state and the
// result bundle passed from the probe controller to the output stage.
// ----------------------------------------------------------------------------
package lph_pkg;

   // Default parameter values
   localparam int DEF_TABLE_DEPTH = 128;
   localparam int DEF_VALUE_BITS  = 32;

   // Fixed field widths
   localparam int OPER_BITS   = 2;
   localparam int KEY_BITS    = 31;
   localparam int DATA_BITS   = 32;
   localparam int STATUS_BITS = 3;
   localparam int FOUND_BITS  = 32;
   localparam int ENTRY_BITS  = 8;
   localparam int SLOT_BITS   = 2;

   typedef enum logic [OPER_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2
   } lph_op_type;

   typedef enum logic [SLOT_BITS-1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_DELETED = 2'd2
   } lph_slot_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_PRESENT   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_FOUND     = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_REMOVED   = 3'd5
   } lph_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_RESULT
   } lph_state_type;

   typedef struct packed {
      lph_status_type         status;
      logic [FOUND_BITS-1:0]  found_value;
      logic [ENTRY_BITS-1:0]  entry_count;
      logic                   is_empty;
   } lph_rsp_type;

endpackage

FILE: rtl/lph_if.sv
// ----------------------------------------------------------------------------
// lph_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface lph_req_if;
   logic                          valid;
   logic                          ready;
   logic [lph_pkg::OPER_BITS-1:0] operation;
   logic [lph_pkg::KEY_BITS-1:0]  key;
   logic [lph_pkg::DATA_BITS-1:0] value;

   modport source (output valid, output operation, output key, output value, input ready);
   modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lph_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lph_pkg::STATUS_BITS-1:0] status;
   logic [lph_pkg::FOUND_BITS-1:0]  found_value;
   logic [lph_pkg::ENTRY_BITS-1:0]  entry_count;
   logic                            is_empty;

   modport source (output valid, output status, output found_value, output entry_count,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input found_value, input entry_count,
                   input is_empty, output ready);
endinterface

FILE: rtl/lph_ram.sv
// ----------------------------------------------------------------------------
// lph_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lph_mod_unit.sv
// ----------------------------------------------------------------------------
// lph_mod_unit: home slot calculation
// Reduces a key modulo the table depth by a registered reciprocal quotient and
// remainder step; a power-of-two depth takes the low key bits directly.
// ----------------------------------------------------------------------------
module lph_mod_unit #(
   parameter int TABLE_DEPTH = lph_pkg::DEF_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lph_pkg::KEY_BITS-1:0]   key,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] rem
);
   import lph_pkg::*;

   localparam int   IDX_W   = $clog2(TABLE_DEPTH);
   localparam int   SHIFT   = KEY_BITS + IDX_W;
   localparam int   MUL_W   = KEY_BITS + 1;
   localparam int   PROD_W  = KEY_BITS + MUL_W;
   localparam bit   IS_POW2 = ((1 << IDX_W) == TABLE_DEPTH);
   // Rounded-up reciprocal; exact quotient for every key of KEY_BITS bits
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
   localparam logic [MUL_W-1:0] RECIP     = MUL_W'(RECIP_WIDE);
   localparam logic [IDX_W-1:0] DEPTH_LOW = IDX_W'(TABLE_DEPTH);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [IDX_W-1:0]    keylo_ff, keylo_in;
   logic [IDX_W-1:0]    quot_ff,  quot_in;
   logic [IDX_W-1:0]    rem_ff,   rem_in;

   logic [PROD_W-1:0]   product;
   logic [2*IDX_W-1:0]  back;
   logic [IDX_W-1:0]    rem_calc;

   // Quotient from the reciprocal, then subtract quotient times depth;
   // only the low index bits of each are needed since the remainder fits
   always_comb begin
      product  = PROD_W'(key) * PROD_W'(RECIP);
      back     = (2*IDX_W)'(quot_ff) * (2*IDX_W)'(DEPTH_LOW);
      rem_calc = keylo_ff - back[IDX_W-1:0];
   end

   // Sequence the reduction
   always_comb begin
      busy_in  = 1'b0;
      done_in  = 1'b0;
      keylo_in = keylo_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         if (IS_POW2) begin
            rem_in  = key[IDX_W-1:0];
            done_in = 1'b1;
         end else begin
            busy_in  = 1'b1;
            keylo_in = key[IDX_W-1:0];
            quot_in  = product[SHIFT +: IDX_W];
         end
      end else if (busy_ff) begin
         rem_in  = rem_calc;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      keylo_ff <= keylo_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/lph_probe_ctrl.sv
// ----------------------------------------------------------------------------
// lph_probe_ctrl: sequencer and slot table
// Clears the table after reset, hashes the key, walks the probe path one
// slot per cycle and updates slots and the occupied count.
// ----------------------------------------------------------------------------
module lph_probe_ctrl #(
   parameter int TABLE_DEPTH = lph_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_BITS  = lph_pkg::DEF_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   lph_req_if.sink              req_ch,
   input  logic                 rsp_free,
   output logic                 rsp_load,
   output lph_pkg::lph_rsp_type rsp_data
);
   import lph_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W = SLOT_BITS + KEY_BITS + VALUE_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

   lph_state_type          state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   logic [OPER_BITS-1:0]   op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   lph_status_type         status_ff, status_in;
   logic [VALUE_BITS-1:0]  found_ff, found_in;

   // Hash unit and table memory
   logic                   hash_start;
   logic                   hash_done;
   logic [IDX_W-1:0]       hash_rem;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [WORD_W-1:0]      wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [WORD_W-1:0]      rd_word;

   // Request decode
   logic                   req_fire;
   logic                   early_full;
   logic                   early_bad;
   logic [VALUE_BITS+DATA_BITS-1:0] val_wide;

   // Probe decision
   logic [SLOT_BITS-1:0]   rd_stat;
   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_val;
   logic                   key_match;
   logic                   slot_used;
   logic                   last_step;
   logic [IDX_W-1:0]       idx_nxt;
   logic                   pr_done;
   logic                   pr_wr;
   logic                   pr_inc;
   logic                   pr_dec;
   lph_status_type         pr_status;
   logic [WORD_W-1:0]      pr_word;

   // Result widening
   logic [VALUE_BITS+FOUND_BITS-1:0] found_wide;
   logic [CNT_W+ENTRY_BITS-1:0]      count_wide;

   lph_mod_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_ch.key),
      .done  (hash_done),
      .rem   (hash_rem)
   );

   lph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Decode the incoming request
   always_comb begin
      req_fire   = req_ch.valid && req_ch.ready;
      early_full = (req_ch.operation == OP_INSERT) && (count_ff >= FULL_CNT);
      early_bad  = !(req_ch.operation inside {OP_INSERT, OP_SEARCH, OP_REMOVE});
      val_wide   = {{VALUE_BITS{1'b0}}, req_ch.value};
   end

   // Examine the slot read back for the current probe index
   always_comb begin
      rd_stat   = rd_word[WORD_W-1 -: SLOT_BITS];
      rd_key    = rd_word[VALUE_BITS +: KEY_BITS];
      rd_val    = rd_word[VALUE_BITS-1:0];
      key_match = (rd_key == key_ff);
      slot_used = (rd_stat == SLOT_USED);
      last_step = (step_ff == LAST_IDX);
      idx_nxt   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

      pr_done   = 1'b0;
      pr_wr     = 1'b0;
      pr_inc    = 1'b0;
      pr_dec    = 1'b0;
      pr_status = STAT_NOT_FOUND;
      pr_word   = {SLOT_USED, key_ff, val_ff};
      case (op_ff)
         OP_INSERT: begin
            if (slot_used && key_match) begin
               pr_done   = 1'b1;
               pr_status = STAT_PRESENT;
            end else if (!slot_used) begin
               pr_done   = 1'b1;
               pr_wr     = 1'b1;
               pr_inc    = 1'b1;
               pr_status = STAT_INSERTED;
            end else if (last_step) begin
               pr_done   = 1'b1;
               pr_status = STAT_FULL;
            end
         end
         OP_SEARCH, OP_REMOVE: begin
            if (rd_stat == SLOT_EMPTY) begin
               pr_done = 1'b1;
            end else if (slot_used && key_match) begin
               pr_done = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  pr_wr     = 1'b1;
                  pr_dec    = 1'b1;
                  pr_word   = {SLOT_DELETED, rd_key, rd_val};
                  pr_status = STAT_REMOVED;
               end else begin
                  pr_status = STAT_FOUND;
               end
            end else if (last_step) begin
               pr_done = 1'b1;
            end
         end
         default: begin
            pr_done = 1'b1;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = (early_full || early_bad) ? S_RESULT : S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (pr_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Outputs: handshake, hash start and memory ports
   always_comb begin
      req_ch.ready = 1'b0;
      hash_start   = 1'b0;
      rsp_load     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = pr_word;
      rd_en        = 1'b0;
      rd_addr      = idx_nxt;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {SLOT_EMPTY, {(WORD_W-SLOT_BITS){1'b0}}};
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            hash_start   = req_fire && !early_full && !early_bad;
         end
         S_HASH: begin
            rd_en   = hash_done;
            rd_addr = hash_rem;
         end
         S_PROBE: begin
            wr_en = pr_wr;
            rd_en = !pr_done;
         end
         S_RESULT: begin
            rsp_load = rsp_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Datapath register updates
   always_comb begin
      clr_in    = clr_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_ch.operation;
               key_in    = req_ch.key;
               val_in    = val_wide[VALUE_BITS-1:0];
               found_in  = '0;
               status_in = early_full ? STAT_FULL : STAT_NOT_FOUND;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               idx_in  = hash_rem;
               step_in = '0;
            end
         end
         S_PROBE: begin
            if (pr_done) begin
               status_in = pr_status;
               found_in  = (pr_status == STAT_FOUND) ? rd_val : '0;
               if (pr_inc) begin
                  count_in = count_ff + 1'b1;
               end else if (pr_dec && (count_ff != '0)) begin
                  count_in = count_ff - 1'b1;
               end
            end else begin
               idx_in  = idx_nxt;
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   // Assemble the result item
   always_comb begin
      found_wide           = {{FOUND_BITS{1'b0}}, found_ff};
      count_wide           = {{ENTRY_BITS{1'b0}}, count_ff};
      rsp_data.status      = status_ff;
      rsp_data.found_value = found_wide[FOUND_BITS-1:0];
      rsp_data.entry_count = count_wide[ENTRY_BITS-1:0];
      rsp_data.is_empty    = (count_ff == '0);
   end

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// A request is hashed to its home slot (reciprocal key reduction, or the low
// key bits for a power-of-two depth), then walks 1 to TABLE_DEPTH slots; a
// full table or an unknown operation skips both. One request at a time; the
// next is taken in the cycle after the response is loaded. Throughput is set
// by the probe walk, one table read per slot, and by response back-pressure.
// After reset the table is cleared before the first request is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_DEPTH = lph_pkg::DEF_TABLE_DEPTH,
   parameter int VALUE_BITS  = lph_pkg::DEF_VALUE_BITS
) (
   input  logic      clock,
   input  logic      reset,
   lph_req_if.sink   req_ch,
   lph_rsp_if.source rsp_ch
);
   import lph_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   lph_rsp_type rsp_data_ff, rsp_data_in;
   logic        rsp_free;
   logic        rsp_load;
   lph_rsp_type rsp_next;

   lph_probe_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_free (rsp_free),
      .rsp_load (rsp_load),
      .rsp_data (rsp_next)
   );

   // Output register: load a new result when the slot is free, drop on transfer
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_ch.ready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_data_ff.status;
   assign rsp_ch.found_value = rsp_data_ff.found_value;
   assign rsp_ch.entry_count = rsp_data_ff.entry_count;
   assign rsp_ch.is_empty    = rsp_data_ff.is_empty;

endmodule
